[src/spm_pkg.sv]
// shared constants, types and pan coefficient table for the stereo pan mixer
package spm_pkg;

    localparam int CHANNELS      = 8;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 16;
    localparam int LEVEL_BITS    = 8;
    localparam int RETURNS       = 4;
    localparam int OUTPUTS       = 6;

    localparam int LANE_STAGES   = 3;
    localparam int MERGE_STAGES  = 3;
    localparam int PIPE_STAGES   = LANE_STAGES + MERGE_STAGES;

    localparam int PAN_SPAN      = 254;
    localparam int IDX_BITS      = 8;
    localparam int COEF_FRAC     = 30;
    localparam logic [63:0] PI_FIX = 64'd3373259426;

    localparam int SG_BITS       = SAMPLE_BITS + LEVEL_BITS + 1;
    localparam int PAN_BITS      = SG_BITS + COEF_BITS + 1;
    localparam int SEND_BITS     = PAN_BITS + LEVEL_BITS + 1;
    localparam int RET_BITS      = SG_BITS;
    localparam int MIX_BITS      = PAN_BITS + $clog2(CHANNELS) + 2;
    localparam int BUS_BITS      = SEND_BITS + $clog2(CHANNELS) + 1;
    localparam int MASTER_SHIFT  = COEF_BITS + LEVEL_BITS - 2;
    localparam int SEND_SHIFT    = COEF_BITS + 2 * LEVEL_BITS - 3;

    localparam int CH_REG_BITS   = CHANNELS * LEVEL_BITS;
    localparam int RET_REG_BITS  = 2 * LEVEL_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam int IN_BITS       = (CHANNELS + RETURNS) * SAMPLE_BITS;
    localparam int OUT_BITS      = OUTPUTS * SAMPLE_BITS;
    localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAINS   = 3'd0,
        CFG_PANS    = 3'd1,
        CFG_SEND_A  = 3'd2,
        CFG_SEND_B  = 3'd3,
        CFG_RETURNS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LANE_STAGES-1:0]  lane_en;
        logic [MERGE_STAGES-1:0] merge_en;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [PAN_BITS-1:0]  left;
        logic signed [PAN_BITS-1:0]  right;
        logic signed [SEND_BITS-1:0] a_left;
        logic signed [SEND_BITS-1:0] a_right;
        logic signed [SEND_BITS-1:0] b_left;
        logic signed [SEND_BITS-1:0] b_right;
    } t_lane_out;

    typedef logic [COEF_BITS-1:0] t_coef_table [0:PAN_SPAN];

    // quarter-wave cosine, fixed-point taylor series evaluated at elaboration
    function automatic t_coef_table build_coef_table();
        t_coef_table tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        for (int k = 0; k <= PAN_SPAN; k++) begin
            x    = (64'(k) * PI_FIX + 64'(PAN_SPAN)) / 64'(2 * PAN_SPAN);
            x2   = (x * x) >> COEF_FRAC;
            term = 64'd1 << COEF_FRAC;
            sum  = term;
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> COEF_FRAC) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rnd    = (sum + (64'd1 << (COEF_FRAC - COEF_BITS))) >> (COEF_FRAC + 1 - COEF_BITS);
            tbl[k] = rnd[COEF_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam t_coef_table COEF_TABLE = build_coef_table();

endpackage

[src/stereo_pan_mixer_with_aux_sends_core.sv]
// top level of the eight channel equal power pan mixer with two aux sends
// Takes one frame per clock while s_axis_tready is high and presents its mix on m_axis once the
// beat has passed through the registered stages of the pipeline in order: three lane
// stages (gain, pan coefficient, send level multipliers) and three merge stages (lane sum
// tree, total with returns and rounding, saturation into the output register). A stage holds
// its beat only while the stage after it holds one that cannot move, so the input keeps
// accepting while a finished mix waits on m_axis_tready until all six stages are full;
// s_axis_tready follows m_axis_tready combinationally. The configuration port is always
// ready; the user must write registers only while no frame is in flight, as the block does
// not enforce it, and there is no start-up sweep after reset.
module stereo_pan_mixer_with_aux_sends_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // channel_0_sample .. channel_7_sample, return_a_left, return_a_right,
    // return_b_left, return_b_right
    input  logic [spm_pkg::IN_BYTES_BITS-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // master_left, master_right, send_a_left, send_a_right, send_b_left, send_b_right
    output logic [spm_pkg::OUT_BYTES_BITS-1:0]      m_axis_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [spm_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import spm_pkg::*;

    logic [CH_REG_BITS-1:0]  r_gains;
    logic [CH_REG_BITS-1:0]  r_pans;
    logic [CH_REG_BITS-1:0]  r_send_a;
    logic [CH_REG_BITS-1:0]  r_send_b;
    logic [RET_REG_BITS-1:0] r_ret_lvl;

    logic [PIPE_STAGES-1:0]  r_vld;
    logic [PIPE_STAGES-1:0]  n_vld;
    logic [PIPE_STAGES-1:0]  pipe_en;
    t_pipe_ctl               ctl;
    t_lane_out               lane_out [CHANNELS];
    logic [OUT_BITS-1:0]     result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains   <= {CHANNELS{8'h80}};
            r_pans    <= '0;
            r_send_a  <= '0;
            r_send_b  <= '0;
            r_ret_lvl <= {2{8'h80}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAINS:   r_gains   <= i_cfg_data[CH_REG_BITS-1:0];
                CFG_PANS:    r_pans    <= i_cfg_data[CH_REG_BITS-1:0];
                CFG_SEND_A:  r_send_a  <= i_cfg_data[CH_REG_BITS-1:0];
                CFG_SEND_B:  r_send_b  <= i_cfg_data[CH_REG_BITS-1:0];
                CFG_RETURNS: r_ret_lvl <= i_cfg_data[RET_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        pipe_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_axis_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            pipe_en[i] = !r_vld[i] || pipe_en[i+1];
        end
        if (pipe_en[0]) begin
            n_vld[0] = s_axis_tvalid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (pipe_en[i]) begin
                n_vld[i] = r_vld[i-1];
            end else begin
                n_vld[i] = r_vld[i];
            end
        end
        ctl.lane_en  = pipe_en[LANE_STAGES-1:0];
        ctl.merge_en = pipe_en[PIPE_STAGES-1:LANE_STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = pipe_en[0];
    assign m_axis_tvalid = r_vld[PIPE_STAGES-1];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        spm_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_sample ($signed(s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS])),
            .i_gain   (r_gains[c*LEVEL_BITS +: LEVEL_BITS]),
            .i_pan    (r_pans[c*LEVEL_BITS +: LEVEL_BITS]),
            .i_send_a (r_send_a[c*LEVEL_BITS +: LEVEL_BITS]),
            .i_send_b (r_send_b[c*LEVEL_BITS +: LEVEL_BITS]),
            .o_lane   (lane_out[c])
        );
    end

    spm_merge u_merge (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_lane    (lane_out),
        .i_returns (s_axis_tdata[IN_BITS-1:CHANNELS*SAMPLE_BITS]),
        .i_ret_lvl (r_ret_lvl),
        .o_result  (result)
    );

    assign m_axis_tdata = OUT_BYTES_BITS'(result);

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> s_axis_tready)
        else $error("input stalled with an empty pipeline");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("beat taken into a full stalled pipeline");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[PIPE_STAGES-2]))
        else $error("output beat without a beat in the stage before");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

[src/spm_lane.sv]
// one channel lane: gain, equal power pan and send level products
module spm_lane (
    input  logic                                      i_clk,
    input  spm_pkg::t_pipe_ctl                        i_ctl,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic [spm_pkg::LEVEL_BITS-1:0]            i_gain,
    input  logic [spm_pkg::LEVEL_BITS-1:0]            i_pan,
    input  logic [spm_pkg::LEVEL_BITS-1:0]            i_send_a,
    input  logic [spm_pkg::LEVEL_BITS-1:0]            i_send_b,
    output spm_pkg::t_lane_out                        o_lane
);
    import spm_pkg::*;

    logic signed [LEVEL_BITS-1:0] pan_c;
    logic signed [LEVEL_BITS:0]   pan_ofs;
    logic [IDX_BITS-1:0]          k_l;
    logic [IDX_BITS-1:0]          k_r;

    logic signed [SG_BITS-1:0]    r_sg;
    logic [COEF_BITS-1:0]         r_cl;
    logic [COEF_BITS-1:0]         r_cr;
    logic signed [PAN_BITS-1:0]   r_sl;
    logic signed [PAN_BITS-1:0]   r_sr;
    t_lane_out                    r_out;

    // hard left code folds onto its neighbor
    always_comb begin
        pan_c   = ($signed(i_pan) == -LEVEL_BITS'(128)) ? LEVEL_BITS'(-127) : $signed(i_pan);
        pan_ofs = (LEVEL_BITS + 1)'(pan_c) + (LEVEL_BITS + 1)'(127);
        k_l     = pan_ofs[IDX_BITS-1:0];
        k_r     = IDX_BITS'(PAN_SPAN) - k_l;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_en[0]) begin
            r_sg <= SG_BITS'(i_sample) * SG_BITS'($signed({1'b0, i_gain}));
            r_cl <= COEF_TABLE[k_l];
            r_cr <= COEF_TABLE[k_r];
        end
        if (i_ctl.lane_en[1]) begin
            r_sl <= PAN_BITS'(r_sg) * PAN_BITS'($signed({1'b0, r_cl}));
            r_sr <= PAN_BITS'(r_sg) * PAN_BITS'($signed({1'b0, r_cr}));
        end
        if (i_ctl.lane_en[2]) begin
            r_out.left    <= r_sl;
            r_out.right   <= r_sr;
            r_out.a_left  <= SEND_BITS'(r_sl) * SEND_BITS'($signed({1'b0, i_send_a}));
            r_out.a_right <= SEND_BITS'(r_sr) * SEND_BITS'($signed({1'b0, i_send_a}));
            r_out.b_left  <= SEND_BITS'(r_sl) * SEND_BITS'($signed({1'b0, i_send_b}));
            r_out.b_right <= SEND_BITS'(r_sr) * SEND_BITS'($signed({1'b0, i_send_b}));
        end
    end

    assign o_lane = r_out;

endmodule

[src/spm_merge.sv]
// lane summing tree, aux returns, rounding and saturation to the output register
module spm_merge (
    input  logic                                   i_clk,
    input  spm_pkg::t_pipe_ctl                     i_ctl,
    input  spm_pkg::t_lane_out                     i_lane [spm_pkg::CHANNELS],
    input  logic [spm_pkg::RETURNS*spm_pkg::SAMPLE_BITS-1:0] i_returns,
    input  logic [spm_pkg::RET_REG_BITS-1:0]       i_ret_lvl,
    output logic [spm_pkg::OUT_BITS-1:0]           o_result
);
    import spm_pkg::*;

    localparam int HALF = CHANNELS / 2;
    localparam logic signed [MIX_BITS-1:0] M_HI = MIX_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIX_BITS-1:0] M_LO = ~M_HI;
    localparam logic signed [BUS_BITS-1:0] B_HI = BUS_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [BUS_BITS-1:0] B_LO = ~B_HI;
    localparam logic signed [MIX_BITS-1:0] M_RND = MIX_BITS'(1) << (MASTER_SHIFT - 1);
    localparam logic signed [BUS_BITS-1:0] B_RND = BUS_BITS'(1) << (SEND_SHIFT - 1);

    function automatic logic [SAMPLE_BITS-1:0] sat_master(input logic signed [MIX_BITS-1:0] v);
        logic signed [MIX_BITS-1:0] q;
        logic [SAMPLE_BITS-1:0]     r;
        q = v >>> MASTER_SHIFT;
        if (q > M_HI) begin
            r = M_HI[SAMPLE_BITS-1:0];
        end else if (q < M_LO) begin
            r = M_LO[SAMPLE_BITS-1:0];
        end else begin
            r = q[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_bus(input logic signed [BUS_BITS-1:0] v);
        logic signed [BUS_BITS-1:0] q;
        logic [SAMPLE_BITS-1:0]     r;
        q = v >>> SEND_SHIFT;
        if (q > B_HI) begin
            r = B_HI[SAMPLE_BITS-1:0];
        end else if (q < B_LO) begin
            r = B_LO[SAMPLE_BITS-1:0];
        end else begin
            r = q[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [RET_BITS-1:0] n_ret [RETURNS];
    logic signed [RET_BITS-1:0] r_ret0 [RETURNS];
    logic signed [RET_BITS-1:0] r_ret1 [RETURNS];
    logic signed [RET_BITS-1:0] r_ret2 [RETURNS];
    logic signed [RET_BITS-1:0] r_ret3 [RETURNS];

    logic signed [MIX_BITS-1:0] n_ml [2];
    logic signed [MIX_BITS-1:0] n_mr [2];
    logic signed [BUS_BITS-1:0] n_al [2];
    logic signed [BUS_BITS-1:0] n_ar [2];
    logic signed [BUS_BITS-1:0] n_bl [2];
    logic signed [BUS_BITS-1:0] n_br [2];

    logic signed [MIX_BITS-1:0] r_ml [2];
    logic signed [MIX_BITS-1:0] r_mr [2];
    logic signed [BUS_BITS-1:0] r_al [2];
    logic signed [BUS_BITS-1:0] r_ar [2];
    logic signed [BUS_BITS-1:0] r_bl [2];
    logic signed [BUS_BITS-1:0] r_br [2];

    logic signed [MIX_BITS-1:0] r_tml;
    logic signed [MIX_BITS-1:0] r_tmr;
    logic signed [BUS_BITS-1:0] r_tal;
    logic signed [BUS_BITS-1:0] r_tar;
    logic signed [BUS_BITS-1:0] r_tbl;
    logic signed [BUS_BITS-1:0] r_tbr;

    logic [OUT_BITS-1:0]        r_result;

    // returns a left, a right, b left, b right
    always_comb begin
        for (int i = 0; i < RETURNS; i++) begin
            n_ret[i] = RET_BITS'($signed(i_returns[i*SAMPLE_BITS +: SAMPLE_BITS]))
                     * RET_BITS'($signed({1'b0, i_ret_lvl[(i/2)*LEVEL_BITS +: LEVEL_BITS]}));
        end
    end

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_ml[h] = '0;
            n_mr[h] = '0;
            n_al[h] = '0;
            n_ar[h] = '0;
            n_bl[h] = '0;
            n_br[h] = '0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (c < HALF) begin
                n_ml[0] = n_ml[0] + MIX_BITS'(i_lane[c].left);
                n_mr[0] = n_mr[0] + MIX_BITS'(i_lane[c].right);
                n_al[0] = n_al[0] + BUS_BITS'(i_lane[c].a_left);
                n_ar[0] = n_ar[0] + BUS_BITS'(i_lane[c].a_right);
                n_bl[0] = n_bl[0] + BUS_BITS'(i_lane[c].b_left);
                n_br[0] = n_br[0] + BUS_BITS'(i_lane[c].b_right);
            end else begin
                n_ml[1] = n_ml[1] + MIX_BITS'(i_lane[c].left);
                n_mr[1] = n_mr[1] + MIX_BITS'(i_lane[c].right);
                n_al[1] = n_al[1] + BUS_BITS'(i_lane[c].a_left);
                n_ar[1] = n_ar[1] + BUS_BITS'(i_lane[c].a_right);
                n_bl[1] = n_bl[1] + BUS_BITS'(i_lane[c].b_left);
                n_br[1] = n_br[1] + BUS_BITS'(i_lane[c].b_right);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RETURNS; i++) begin
            if (i_ctl.lane_en[0]) r_ret0[i] <= n_ret[i];
            if (i_ctl.lane_en[1]) r_ret1[i] <= r_ret0[i];
            if (i_ctl.lane_en[2]) r_ret2[i] <= r_ret1[i];
            if (i_ctl.merge_en[0]) r_ret3[i] <= r_ret2[i];
        end
        if (i_ctl.merge_en[0]) begin
            r_ml <= n_ml;
            r_mr <= n_mr;
            r_al <= n_al;
            r_ar <= n_ar;
            r_bl <= n_bl;
            r_br <= n_br;
        end
        if (i_ctl.merge_en[1]) begin
            r_tml <= r_ml[0] + r_ml[1] + M_RND
                   + (MIX_BITS'(r_ret3[0]) <<< (COEF_BITS - 1))
                   + (MIX_BITS'(r_ret3[2]) <<< (COEF_BITS - 1));
            r_tmr <= r_mr[0] + r_mr[1] + M_RND
                   + (MIX_BITS'(r_ret3[1]) <<< (COEF_BITS - 1))
                   + (MIX_BITS'(r_ret3[3]) <<< (COEF_BITS - 1));
            r_tal <= r_al[0] + r_al[1] + B_RND;
            r_tar <= r_ar[0] + r_ar[1] + B_RND;
            r_tbl <= r_bl[0] + r_bl[1] + B_RND;
            r_tbr <= r_br[0] + r_br[1] + B_RND;
        end
        if (i_ctl.merge_en[2]) begin
            r_result <= {sat_bus(r_tbr), sat_bus(r_tbl), sat_bus(r_tar), sat_bus(r_tal),
                         sat_master(r_tmr), sat_master(r_tml)};
        end
    end

    assign o_result = r_result;

endmodule

[bench/stereo_pan_mixer_with_aux_sends_core_tb.sv]
// self-checking bench for the stereo pan mixer core: directed rows, random frames, gain/pan/send sweeps
module stereo_pan_mixer_with_aux_sends_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int SW       = SAMPLE_BITS;
    localparam int IN_W     = IN_BYTES_BITS;
    localparam int OUT_W    = OUT_BYTES_BITS;
    localparam int FIELDS   = CHANNELS + RETURNS;
    localparam int RET_A_L  = CHANNELS;
    localparam int RET_A_R  = CHANNELS + 1;
    localparam int RET_B_L  = CHANNELS + 2;
    localparam int RET_B_R  = CHANNELS + 3;
    localparam int SPAN     = 254;
    localparam int MASTER_N = COEF_BITS + 6;
    localparam int SEND_N   = COEF_BITS + 13;
    localparam logic [SW-1:0] S_MAX = 16'h7FFF;
    localparam logic [SW-1:0] S_MIN = 16'h8000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_HI = 3'd7;
    localparam int SETTLE_CYCLES = PIPE_STAGES + 2;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int CHOKE_PHASE   = 2;
    localparam int CHOKE_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [63:0]             reg_val;
        logic [IN_W-1:0]         frame;
        logic                    typed_in;
        logic [OUT_W-1:0]        mix;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_W-1:0]          s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         m_axis_tdata;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    longint      pan_coef [0:SPAN];
    logic [63:0] gains_m, pans_m, send_a_m, send_b_m;
    logic [15:0] returns_m;

    logic [OUT_W-1:0] mix_due [$];
    logic [OUT_W-1:0] mix_want;
    t_row             plan [$];
    string            out_names [6] = '{"master_left", "master_right", "send_a_left",
                                        "send_a_right", "send_b_left", "send_b_right"};
    int               errors = 0;
    int               cycles = 0;
    bit               src_gaps = 1'b1;
    bit               offering = 1'b0;
    logic             choke_req = 1'b0;
    logic             choke_done = 1'b0;
    int               sink_wait = 0;
    int               sink_calm = 0;

    stereo_pan_mixer_with_aux_sends_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // quarter-wave cosine in q1.15, taylor series with 30 fraction bits
    function automatic longint cos_q15(input int k);
        longint unsigned x, x2, term, acc;
        x    = (longint'(k) * 64'd3373259426 + SPAN) / (2 * SPAN);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = term;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return longint'((acc + (64'd1 << 14)) >> 15);
    endfunction

    function automatic logic [SW-1:0] round_sat(input longint v, input int n);
        longint r;
        r = (v + (longint'(1) << (n - 1))) >>> n;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[SW-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] mix_frame(input logic [IN_W-1:0] f);
        logic signed [SW-1:0] smp;
        logic signed [7:0]    pan_b;
        longint s, g, sa, sb, sl, sr, lva, lvb, unit;
        longint ml, mr, al, ar, bl, br;
        int p;
        logic [OUT_W-1:0] o;
        ml = 0; mr = 0; al = 0; ar = 0; bl = 0; br = 0;
        unit = longint'(1) << (COEF_BITS - 1);
        for (int c = 0; c < CHANNELS; c++) begin
            smp   = f[SW*c +: SW];
            s     = smp;
            g     = longint'(gains_m[8*c +: 8]);
            sa    = longint'(send_a_m[8*c +: 8]);
            sb    = longint'(send_b_m[8*c +: 8]);
            pan_b = pans_m[8*c +: 8];
            p     = pan_b;
            if (p < -127) p = -127;
            sl = s * g * pan_coef[p + 127];
            sr = s * g * pan_coef[SPAN - (p + 127)];
            ml += sl;
            mr += sr;
            al += sl * sa;
            ar += sr * sa;
            bl += sl * sb;
            br += sr * sb;
        end
        lva = longint'(returns_m[7:0]);
        lvb = longint'(returns_m[15:8]);
        smp = f[SW*RET_A_L +: SW]; s = smp; ml += s * lva * unit;
        smp = f[SW*RET_A_R +: SW]; s = smp; mr += s * lva * unit;
        smp = f[SW*RET_B_L +: SW]; s = smp; ml += s * lvb * unit;
        smp = f[SW*RET_B_R +: SW]; s = smp; mr += s * lvb * unit;
        o = '0;
        o[0*SW +: SW] = round_sat(ml, MASTER_N);
        o[1*SW +: SW] = round_sat(mr, MASTER_N);
        o[2*SW +: SW] = round_sat(al, SEND_N);
        o[3*SW +: SW] = round_sat(ar, SEND_N);
        o[4*SW +: SW] = round_sat(bl, SEND_N);
        o[5*SW +: SW] = round_sat(br, SEND_N);
        return o;
    endfunction

    function automatic logic [IN_W-1:0] uni(input logic [SW-1:0] ch, input logic [SW-1:0] ret);
        logic [IN_W-1:0] f;
        f = '0;
        for (int i = 0; i < FIELDS; i++) f[SW*i +: SW] = (i < CHANNELS) ? ch : ret;
        return f;
    endfunction

    function automatic logic [IN_W-1:0] one(input int idx, input logic [SW-1:0] v);
        logic [IN_W-1:0] f;
        f = '0;
        f[SW*idx +: SW] = v;
        return f;
    endfunction

    function automatic logic [OUT_W-1:0] outs(input logic [SW-1:0] ml, mr, al, ar, bl, br);
        logic [OUT_W-1:0] o;
        o = '0;
        o[6*SW-1:0] = {br, bl, ar, al, mr, ml};
        return o;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] v);
        t_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    function automatic t_row frame_row(input logic [IN_W-1:0] f, input logic typed_in,
                                       input logic [OUT_W-1:0] mix);
        t_row r;
        r = '0;
        r.frame    = f;
        r.typed_in = typed_in;
        r.mix      = mix;
        return r;
    endfunction

    function automatic void queue_row(input t_row r);
        plan = {plan, r};
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return SW'($urandom_range(0, 15) - 8);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_frame();
        logic [IN_W-1:0] f;
        int solo;
        f = '0;
        solo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, FIELDS - 1) : -1;
        for (int i = 0; i < FIELDS; i++) begin
            if (solo < 0 || solo == i) f[SW*i +: SW] = rand_sample();
        end
        return f;
    endfunction

    function automatic logic [63:0] pick_bytes();
        logic [63:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = {8{8'h80}};
            3: v = {$urandom, $urandom};
            default: begin
                for (int b = 0; b < 8; b++) begin
                    case ($urandom_range(0, 5))
                        0: v[8*b +: 8] = 8'h00;
                        1: v[8*b +: 8] = 8'h7F;
                        2: v[8*b +: 8] = 8'h80;
                        3: v[8*b +: 8] = 8'h81;
                        4: v[8*b +: 8] = 8'hFF;
                        default: v[8*b +: 8] = 8'($urandom);
                    endcase
                end
            end
        endcase
        return v;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAINS:   gains_m   = v;
            CFG_PANS:    pans_m    = v;
            CFG_SEND_A:  send_a_m  = v;
            CFG_SEND_B:  send_b_m  = v;
            CFG_RETURNS: returns_m = v[15:0];
            default: ;
        endcase
    endtask

    task automatic push_frame(input logic [IN_W-1:0] f, input logic typed_in,
                              input logic [OUT_W-1:0] mix);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        mix_due = {mix_due, (typed_in ? mix : mix_frame(f))};
        gap = (src_gaps && $urandom_range(0, 9) < 4) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain the pipe so registers can change
    task automatic settle();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (mix_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sink side: random stalls, calm stretches, one long choke
    always @(posedge i_clk) begin
        if (choke_req && !choke_done) begin
            choke_done    <= 1'b1;
            sink_wait     <= CHOKE_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
        end else begin
            sink_wait <= 0;
            if (sink_calm > 0) begin
                sink_calm     <= sink_calm - 1;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 4) begin
                sink_calm     <= $urandom_range(50, 200);
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                sink_wait     <= idle_len();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mix_due.size() == 0) begin
                $error("output beat with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                mix_want = mix_due.pop_front();
                for (int i = 0; i < OUTPUTS; i++) begin
                    if (m_axis_tdata[SW*i +: SW] !== mix_want[SW*i +: SW]) begin
                        $error("%s expected %0d actual %0d", out_names[i],
                               $signed(mix_want[SW*i +: SW]), $signed(m_axis_tdata[SW*i +: SW]));
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : stim
        logic [63:0] g, p, a, b, r;
        bit prev_cfg;
        for (int k = 0; k <= SPAN; k++) pan_coef[k] = cos_q15(k);
        gains_m   = {8{8'h80}};
        pans_m    = '0;
        send_a_m  = '0;
        send_b_m  = '0;
        returns_m = 16'h8080;

        // reset values: unity gains, center pans, no sends, unity returns
        queue_row(frame_row(uni('0, '0), 1'b1, outs('0, '0, '0, '0, '0, '0)));
        queue_row(frame_row(one(RET_A_L, 16'd1000), 1'b1,
                            outs(16'd1000, '0, '0, '0, '0, '0)));
        queue_row(frame_row(one(RET_B_R, -16'sd1234), 1'b1,
                            outs('0, -16'sd1234, '0, '0, '0, '0)));
        queue_row(frame_row(uni(S_MAX, S_MAX), 1'b1, outs(S_MAX, S_MAX, '0, '0, '0, '0)));
        queue_row(frame_row(uni(S_MIN, S_MIN), 1'b1, outs(S_MIN, S_MIN, '0, '0, '0, '0)));
        queue_row(frame_row(one(0, S_MAX), 1'b0, '0));
        queue_row(frame_row(one(CHANNELS - 1, S_MIN), 1'b0, '0));
        // hot levels, hard pans, pan of -128 on channel 0
        queue_row(cfg_row(CFG_GAINS, '1));
        queue_row(cfg_row(CFG_PANS, 64'h00C0_40FF_017F_8180));
        queue_row(cfg_row(CFG_SEND_A, '1));
        queue_row(cfg_row(CFG_SEND_B, 64'h0120_407F_8081_C0FF));
        queue_row(cfg_row(CFG_RETURNS, 64'hFFFF));
        queue_row(frame_row(one(0, S_MIN), 1'b0, '0));
        queue_row(frame_row(one(1, S_MIN), 1'b0, '0));
        queue_row(frame_row(one(2, S_MAX), 1'b0, '0));
        queue_row(frame_row(uni(S_MAX, S_MAX), 1'b0, '0));
        queue_row(frame_row(uni(S_MIN, '0), 1'b0, '0));
        queue_row(frame_row(uni(16'h1234, -16'sh0567), 1'b0, '0));
        // unmapped indexes must leave every register alone
        queue_row(cfg_row(CFG_NONE_LO, 64'h0));
        queue_row(cfg_row(CFG_NONE_HI, 64'h0));
        queue_row(frame_row(uni(16'h2000, -16'sh3000), 1'b0, '0));
        queue_row(cfg_row(CFG_GAINS, '0));
        queue_row(cfg_row(CFG_RETURNS, 64'h0));
        queue_row(frame_row(uni(S_MAX, S_MAX), 1'b1, outs('0, '0, '0, '0, '0, '0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!prev_cfg) settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                push_frame(plan[i].frame, plan[i].typed_in, plan[i].mix);
            end
            prev_cfg = plan[i].is_cfg;
        end
        if (prev_cfg) i_cfg_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    g = '1; p = '1; a = '1; b = '1; r = '1;
                end
                1: begin
                    g = '0; p = {8{8'h80}}; a = '0; b = '0; r = '1;
                end
                default: begin
                    g = pick_bytes(); p = pick_bytes(); a = pick_bytes();
                    b = pick_bytes(); r = {pick_bytes()};
                end
            endcase
            write_reg(CFG_GAINS, g);
            write_reg(CFG_PANS, p);
            write_reg(CFG_SEND_A, a);
            write_reg(CFG_SEND_B, b);
            write_reg(CFG_RETURNS, r);
            if ($urandom_range(0, 1) == 1) write_reg(CFG_NONE_HI, {$urandom, $urandom});
            i_cfg_valid <= 1'b0;
            src_gaps = (ph != CHOKE_PHASE) && ($urandom_range(0, 3) != 0);
            if (ph == CHOKE_PHASE) choke_req <= 1'b1;
            repeat (PHASE_ITEMS) push_frame(rand_frame(), 1'b0, '0);
        end

        settle();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
src/spm_pkg.sv
src/spm_lane.sv
src/spm_merge.sv
src/stereo_pan_mixer_with_aux_sends_core.sv
bench/stereo_pan_mixer_with_aux_sends_core_tb.sv
